### hdl/bra_pkg.sv
// Shared types, widths, register indexes and level profiles for the bitrate
// resolution adapter. No dependencies; compile first.

package bra_pkg;

    // Field widths
    localparam int LEVEL_W    = 3;
    localparam int RATE_W     = 20;
    localparam int NOW_W      = 40;
    localparam int CD_W       = 20;
    localparam int CNT_W      = 4;
    localparam int ALPHA_W    = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 11;
    localparam int FPS_W      = 5;
    localparam int PCT_W      = 7;
    localparam int KBPS_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Parameter defaults
    localparam int RATE_FRAC_BITS_DEF = 8;
    localparam int TIME_BITS_DEF      = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_COOLDOWN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_COOLDOWN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_CONFIRM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FALL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_RISE    = 3'd4;

    // Configuration reset values
    localparam logic [CD_W-1:0]    DOWN_COOLDOWN_RST = 20'd3000;
    localparam logic [CD_W-1:0]    UP_COOLDOWN_RST   = 20'd5000;
    localparam logic [CNT_W-1:0]   UP_CONFIRM_RST    = 4'd3;
    localparam logic [ALPHA_W-1:0] ALPHA_FALL_RST    = 16'd42598;
    localparam logic [ALPHA_W-1:0] ALPHA_RISE_RST    = 16'd26214;

    // Request kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_FORCE  = 1'b1;

    // Video levels
    localparam logic [LEVEL_W-1:0] LVL_OFF   = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_360P  = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_480P  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_720P  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_1080P = 3'd4;

    localparam logic [CNT_W-1:0]  CNT_MAX       = 4'd15;
    localparam logic [KBPS_W-1:0] RESET_AVG_KBPS = 12'd1000;

    typedef struct packed {
        logic [WIDTH_W-1:0]  frame_width;
        logic [HEIGHT_W-1:0] frame_height;
        logic [FPS_W-1:0]    frame_rate;
        logic [PCT_W-1:0]    scale_percent;
    } t_profile;

    function automatic t_profile profile_of(input logic [LEVEL_W-1:0] lvl);
        t_profile p;
        unique case (lvl)
            LVL_OFF:   p = '{11'd0,    11'd0,    5'd0,  7'd0};
            LVL_360P:  p = '{11'd640,  11'd360,  5'd20, 7'd33};
            LVL_480P:  p = '{11'd848,  11'd480,  5'd24, 7'd44};
            LVL_720P:  p = '{11'd1280, 11'd720,  5'd30, 7'd67};
            default:   p = '{11'd1920, 11'd1080, 5'd30, 7'd100};
        endcase
        return p;
    endfunction

    // Average seeded by a forced level, in whole kbps
    function automatic logic [KBPS_W-1:0] seed_kbps(input logic [LEVEL_W-1:0] lvl);
        logic [KBPS_W-1:0] k;
        unique case (lvl)
            LVL_1080P: k = 12'd3500;
            LVL_720P:  k = 12'd2000;
            LVL_480P:  k = 12'd1000;
            default:   k = 12'd450;
        endcase
        return k;
    endfunction

endpackage

### hdl/bra_req_if.sv
// Request channel of the bitrate resolution adapter: valid/ready plus payload.
// Depends on bra_pkg.

interface bra_req_if import bra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [RATE_W-1:0]  bitrate_kbps;
    logic [NOW_W-1:0]   now_ms;
    logic [LEVEL_W-1:0] forced_level;

    modport source (output valid, output req_type, output bitrate_kbps,
                    output now_ms, output forced_level, input ready);
    modport sink   (input valid, input req_type, input bitrate_kbps,
                    input now_ms, input forced_level, output ready);
endinterface

### hdl/bra_res_if.sv
// Result channel of the bitrate resolution adapter: level and its profile.
// Depends on bra_pkg.

interface bra_res_if import bra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LEVEL_W-1:0]  level;
    logic [WIDTH_W-1:0]  frame_width;
    logic [HEIGHT_W-1:0] frame_height;
    logic [FPS_W-1:0]    frame_rate;
    logic [PCT_W-1:0]    scale_percent;

    modport source (output valid, output level, output frame_width,
                    output frame_height, output frame_rate,
                    output scale_percent, input ready);
    modport sink   (input valid, input level, input frame_width,
                     input frame_height, input frame_rate,
                     input scale_percent, output ready);
endinterface

### hdl/bra_target.sv
// Hysteresis target selection: maps the smoothed rate and current level to a
// target level. Depends on bra_pkg.

module bra_target import bra_pkg::*; #(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  logic [RATE_W+RATE_FRAC_BITS-1:0] i_avg,
    input  logic [LEVEL_W-1:0]               i_cur_level,
    output logic [LEVEL_W-1:0]               o_target
);

    localparam int AvgW = RATE_W + RATE_FRAC_BITS;

    localparam logic [AvgW-1:0] T650  = AvgW'(650)  << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T750  = AvgW'(750)  << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T800  = AvgW'(800)  << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T850  = AvgW'(850)  << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T1200 = AvgW'(1200) << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T1400 = AvgW'(1400) << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T1500 = AvgW'(1500) << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T2100 = AvgW'(2100) << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T2500 = AvgW'(2500) << RATE_FRAC_BITS;
    localparam logic [AvgW-1:0] T2600 = AvgW'(2600) << RATE_FRAC_BITS;

    always_comb begin
        unique case (i_cur_level)
            LVL_OFF: begin
                priority if (i_avg >= T2500) o_target = LVL_1080P;
                else if (i_avg >= T1400)     o_target = LVL_720P;
                else if (i_avg >= T800)      o_target = LVL_480P;
                else                         o_target = LVL_360P;
            end
            LVL_1080P: begin
                priority if (i_avg < T750) o_target = LVL_360P;
                else if (i_avg < T1200)    o_target = LVL_480P;
                else if (i_avg < T2100)    o_target = LVL_720P;
                else                       o_target = LVL_1080P;
            end
            LVL_720P: begin
                priority if (i_avg >= T2600) o_target = LVL_1080P;
                else if (i_avg < T750)       o_target = LVL_360P;
                else if (i_avg < T1200)      o_target = LVL_480P;
                else                         o_target = LVL_720P;
            end
            LVL_480P: begin
                priority if (i_avg >= T2600) o_target = LVL_1080P;
                else if (i_avg >= T1500)     o_target = LVL_720P;
                else if (i_avg < T650)       o_target = LVL_360P;
                else                         o_target = LVL_480P;
            end
            default: begin
                priority if (i_avg >= T2600) o_target = LVL_1080P;
                else if (i_avg >= T1500)     o_target = LVL_720P;
                else if (i_avg >= T850)      o_target = LVL_480P;
                else                         o_target = LVL_360P;
            end
        endcase
    end

endmodule

### hdl/bitrate_resolution_adapter.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    req_type, bitrate_kbps, now_ms, forced_level
// o_res     out  valid/ready    level, frame_width, frame_height, frame_rate,
//                               scale_percent
// cfg       in   write enable   i_cfg_idx, i_cfg_data
//
// Each item passes a multiply stage, forming the averaging product a*(x-s) and
// the cooldown compares, and a commit stage, which rounds the average, picks
// the target and commits the level. The average feeds back into the next
// product, so an item enters the multiply stage only after the previous one
// has committed. A request is held in an input register, so a transfer is
// taken while the multiply stage works; a result waits in the output register
// without blocking the next item's multiply. Synchronous active-low reset; no
// clearing pass. Depends on bra_pkg, bra_req_if, bra_res_if and bra_target.

module bitrate_resolution_adapter import bra_pkg::*; #(
    parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bra_req_if.sink               i_req,
    bra_res_if.source             o_res
);

    localparam int AvgW  = RATE_W + RATE_FRAC_BITS;
    localparam int DiffW = AvgW + 1;
    localparam int ProdW = DiffW + ALPHA_W + 1;
    localparam int SumW  = ProdW + 1;
    localparam int NowW  = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
    localparam logic [ALPHA_W:0] ALPHA_ONE_HALF = (ALPHA_W+1)'(1) << (ALPHA_W - 1);
    localparam logic [AvgW-1:0]  AVG_RST = AvgW'(RESET_AVG_KBPS) << RATE_FRAC_BITS;

    // Configuration
    logic [CD_W-1:0]    r_dn_cd, r_up_cd;
    logic [CNT_W-1:0]   r_confirm;
    logic [ALPHA_W-1:0] r_a_fall, r_a_rise;

    // Controller state
    logic [LEVEL_W-1:0]   r_level;
    logic [AvgW-1:0]      r_avg;
    logic [TIME_BITS-1:0] r_last;
    logic [CNT_W-1:0]     r_cnt;

    // Input register
    logic                 r_in_valid;
    logic                 r_in_type;
    logic [RATE_W-1:0]    r_in_rate;
    logic [TIME_BITS-1:0] r_in_now;
    logic [LEVEL_W-1:0]   r_in_forced;

    // Multiply stage
    logic                     r_m_valid;
    logic                     r_m_type;
    logic [RATE_W-1:0]        r_m_rate;
    logic [TIME_BITS-1:0]     r_m_now;
    logic [LEVEL_W-1:0]       r_m_forced;
    logic signed [ProdW-1:0]  r_m_prod;
    logic                     r_m_seed;
    logic                     r_m_down_ok;
    logic                     r_m_up_ok;

    // Output register
    logic     r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    t_profile r_out_prof;

    logic in_fire, mul_load, commit;

    assign in_fire  = i_req.valid && i_req.ready;
    assign mul_load = r_in_valid && !r_m_valid;
    assign commit   = r_m_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || mul_load;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_cd   <= DOWN_COOLDOWN_RST;
            r_up_cd   <= UP_COOLDOWN_RST;
            r_confirm <= UP_CONFIRM_RST;
            r_a_fall  <= ALPHA_FALL_RST;
            r_a_rise  <= ALPHA_RISE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOWN_COOLDOWN: r_dn_cd   <= i_cfg_data[CD_W-1:0];
                CFG_UP_COOLDOWN:   r_up_cd   <= i_cfg_data[CD_W-1:0];
                CFG_UP_CONFIRM:    r_confirm <= i_cfg_data[CNT_W-1:0];
                CFG_ALPHA_FALL:    r_a_fall  <= i_cfg_data[ALPHA_W-1:0];
                CFG_ALPHA_RISE:    r_a_rise  <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (mul_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_type   <= i_req.req_type;
            r_in_rate   <= i_req.bitrate_kbps;
            r_in_now    <= TIME_BITS'(i_req.now_ms[NowW-1:0]);
            r_in_forced <= i_req.forced_level;
        end
    end

    // ---------------- multiply stage ----------------
    logic [AvgW-1:0]         x_in;
    logic signed [DiffW-1:0] diff;
    logic [ALPHA_W-1:0]      alpha;
    logic signed [ProdW-1:0] prod;
    logic [TIME_BITS-1:0]    elapsed;
    logic                    time_fwd;

    always_comb begin
        x_in     = AvgW'(r_in_rate) << RATE_FRAC_BITS;
        diff     = $signed({1'b0, x_in}) - $signed({1'b0, r_avg});
        alpha    = (x_in < r_avg) ? r_a_fall : r_a_rise;
        prod     = diff * $signed({1'b0, alpha});
        elapsed  = r_in_now - r_last;
        time_fwd = r_in_now >= r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (mul_load) begin
            r_m_valid <= 1'b1;
        end else if (commit) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_load) begin
            r_m_type    <= r_in_type;
            r_m_rate    <= r_in_rate;
            r_m_now     <= r_in_now;
            r_m_forced  <= r_in_forced;
            r_m_prod    <= prod;
            r_m_seed    <= (r_avg == '0) || (r_last == '0);
            r_m_down_ok <= time_fwd && (elapsed >= TIME_BITS'(r_dn_cd));
            r_m_up_ok   <= time_fwd && (elapsed >= TIME_BITS'(r_up_cd));
        end
    end

    // ---------------- commit stage ----------------
    logic [AvgW-1:0]        x_m;
    logic signed [SumW-1:0] sum;
    logic [AvgW-1:0]        avg_upd;
    logic [LEVEL_W-1:0]     target;
    logic [LEVEL_W-1:0]     forced_sat;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   never_switched;

    logic [LEVEL_W-1:0]   n_level;
    logic [AvgW-1:0]      n_avg;
    logic [TIME_BITS-1:0] n_last;
    logic [CNT_W-1:0]     n_cnt;

    always_comb begin
        x_m = AvgW'(r_m_rate) << RATE_FRAC_BITS;
        // s + a*(x-s), rounded half up in Q0.16
        sum = $signed({{(SumW-AvgW-ALPHA_W){1'b0}}, r_avg, {ALPHA_W{1'b0}}})
            + SumW'(r_m_prod)
            + $signed(SumW'(ALPHA_ONE_HALF));
        avg_upd = r_m_seed ? x_m : sum[AvgW+ALPHA_W-1:ALPHA_W];
    end

    bra_target #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_target (
        .i_avg       (avg_upd),
        .i_cur_level (r_level),
        .o_target    (target)
    );

    always_comb begin
        forced_sat     = (r_m_forced > LVL_1080P) ? LVL_1080P : r_m_forced;
        cnt_inc        = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
        never_switched = (r_last == '0);
        n_level = r_level;
        n_avg   = r_avg;
        n_last  = r_last;
        n_cnt   = r_cnt;
        priority if (r_m_type == REQ_FORCE) begin
            n_level = forced_sat;
            n_avg   = AvgW'(seed_kbps(forced_sat)) << RATE_FRAC_BITS;
            n_last  = r_m_now;
            n_cnt   = '0;
        end else if (r_m_rate == '0) begin
            // stream off
            n_level = LVL_OFF;
            n_avg   = '0;
            n_last  = '0;
            n_cnt   = '0;
        end else begin
            n_avg = avg_upd;
            priority if (target < r_level) begin
                if (never_switched || r_m_down_ok) begin
                    n_level = r_level - LEVEL_W'(1);
                    n_last  = r_m_now;
                    n_cnt   = '0;
                end
            end else if (target > r_level) begin
                if (never_switched || r_level == LVL_OFF) begin
                    n_level = target;
                    n_last  = r_m_now;
                    n_cnt   = '0;
                end else if (cnt_inc >= r_confirm && r_m_up_ok) begin
                    n_level = target;
                    n_last  = r_m_now;
                    n_cnt   = '0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end else begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LVL_360P;
            r_avg   <= AVG_RST;
            r_last  <= '0;
            r_cnt   <= '0;
        end else if (commit) begin
            r_level <= n_level;
            r_avg   <= n_avg;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_level <= n_level;
            r_out_prof  <= profile_of(n_level);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.level         = r_out_level;
    assign o_res.frame_width   = r_out_prof.frame_width;
    assign o_res.frame_height  = r_out_prof.frame_height;
    assign o_res.frame_rate    = r_out_prof.frame_rate;
    assign o_res.scale_percent = r_out_prof.scale_percent;

`ifndef NO_ASSERTIONS
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_1080P)
        else $error("level register out of range");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid && r_out_level == r_level)
        else $error("committed level not presented");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !commit)
        else $error("result register overwritten while held");

    a_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && r_m_type == REQ_UPDATE && r_m_rate == '0
        |=> r_level == LVL_OFF && r_avg == '0 && r_last == '0)
        else $error("zero rate did not switch off");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_load |=> !mul_load)
        else $error("second item entered multiply stage too early");
`endif

endmodule
